// ===== rtl/rpa_pkg.sv =====
// shared types and constants for the reference-counted page allocator
`timescale 1ns / 1ps

package rpa_pkg;

	// default pool geometry
	localparam int NUM_PAGES_DEF  = 32768;
	localparam int COUNT_BITS_DEF = 8;

	// fixed field widths of the item and result
	localparam int PAGE_W   = 15;
	localparam int SETVAL_W = 8;
	localparam int REFOUT_W = 8;

	// operation codes
	typedef enum logic [2:0] {
		MODE_INIT     = 3'd0,
		MODE_ALLOC    = 3'd1,
		MODE_FREE     = 3'd2,
		MODE_INCREASE = 3'd3,
		MODE_DECREASE = 3'd4,
		MODE_SET      = 3'd5,
		MODE_GET      = 3'd6
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OUT_OF_MEM = 3'd1,
		ST_BAD_PAGE   = 3'd2,
		ST_UNDERFLOW  = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_STACK_FULL = 3'd5
	} status_t;

endpackage

// ===== rtl/refcounted_page_allocator_top.sv =====
// top level of the reference-counted page allocator
`timescale 1ns / 1ps

// Page allocator with a LIFO free stack of page indices and a per-page
// reference count, both held in synchronous RAMs with registered read.
// An item is taken in the idle state, which issues the reads of the count
// RAM and of the stack top; the execute state then waits until the result
// register is free, modifies and writes back, and loads the result
// register. No new item is taken until the current one leaves execute.
// Init instead walks the pages from first_usable_page, if it is in range,
// to the last page and then delivers its result: the walk writes one count
// entry and one stack entry a cycle. After reset the block clears the
// count RAM, one entry a cycle, and holds in_stall high meanwhile;
// configuration writes are taken at all times. Pages handed out by alloc
// come back on result_page; a result waits in its register while
// out_stall is high and the next item is already taken.

module refcounted_page_allocator_top import rpa_pkg::*; #(
	parameter int NUM_PAGES  = NUM_PAGES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [PAGE_W-1:0]   cfg_wr_data,
	// item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic [PAGE_W-1:0]   page_index,
	input  logic [SETVAL_W-1:0] set_value,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PAGE_W-1:0]   result_page,
	output logic [REFOUT_W-1:0] ref_count,
	output logic                freed,
	output logic [2:0]          status
);

	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int DW = $clog2(NUM_PAGES + 1);
	localparam logic [AW-1:0]         LAST_PAGE = AW'(NUM_PAGES - 1);
	localparam logic [DW-1:0]         FULL_DEPTH = DW'(NUM_PAGES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_WALK  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	logic [PAGE_W-1:0]     first_usable_q;
	logic [DW-1:0]         depth_q;
	logic [AW-1:0]         walk_q;
	logic [2:0]            mode_q;
	logic [PAGE_W-1:0]     page_q;
	logic [SETVAL_W-1:0]   setv_q;

	// held result of init while the walk runs
	logic [PAGE_W-1:0]     res_page_q;
	logic [REFOUT_W-1:0]   res_count_q;

	// result register
	logic                  out_valid_q;
	logic [PAGE_W-1:0]     out_page_q;
	logic [REFOUT_W-1:0]   out_count_q;
	logic                  out_freed_q;
	logic [2:0]            out_status_q;

	logic                  in_acc;
	logic                  out_free;
	logic [DW-1:0]         depth_dec;

	// ram ports
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic                  stk_we;
	logic [AW-1:0]         stk_waddr;
	logic [AW-1:0]         stk_wdata;
	logic [AW-1:0]         stk_rdata;

	// execute-stage results
	logic                  page_ok;
	logic                  first_ok;
	logic [PAGE_W-1:0]     ex_page;
	logic [COUNT_BITS-1:0] ex_count;
	logic                  ex_freed;
	status_t               ex_status;
	logic                  ex_cnt_we;
	logic [AW-1:0]         ex_cnt_addr;
	logic [COUNT_BITS-1:0] ex_cnt_data;
	logic                  ex_push;
	logic                  ex_pop;
	logic                  exec_go;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign depth_dec = depth_q - DW'(1);
	assign page_ok   = (32'(page_q) < NUM_PAGES);
	assign first_ok  = (32'(first_usable_q) < NUM_PAGES);
	assign exec_go   = (state_q == S_EXEC) && out_free && (mode_q != MODE_INIT);

	// reference count memory
	rpa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (in_acc),
		.raddr (AW'(page_index)),
		.rdata (cnt_rdata)
	);

	// free stack memory
	rpa_ram #(
		.WIDTH (AW),
		.DEPTH (NUM_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (in_acc),
		.raddr (depth_dec[AW-1:0]),
		.rdata (stk_rdata)
	);

	// operation decode on the read data
	always_comb begin
		ex_page     = page_q;
		ex_count    = cnt_rdata;
		ex_freed    = 1'b0;
		ex_status   = ST_OK;
		ex_cnt_we   = 1'b0;
		ex_cnt_addr = AW'(page_q);
		ex_cnt_data = cnt_rdata;
		ex_push     = 1'b0;
		ex_pop      = 1'b0;
		if (mode_q == MODE_INIT) begin
			if (!page_ok || (page_q >= first_usable_q)) begin
				ex_count = '0;
			end
		end else if (mode_q == MODE_ALLOC) begin
			if (depth_q == '0) begin
				ex_page   = '0;
				ex_count  = '0;
				ex_status = ST_OUT_OF_MEM;
			end else begin
				ex_pop      = 1'b1;
				ex_page     = PAGE_W'(stk_rdata);
				ex_count    = COUNT_BITS'(1);
				ex_cnt_we   = 1'b1;
				ex_cnt_addr = stk_rdata;
				ex_cnt_data = COUNT_BITS'(1);
			end
		end else if (!page_ok) begin
			ex_count  = '0;
			ex_status = ST_BAD_PAGE;
		end else begin
			case (mode_q)
				MODE_FREE: begin
					if (page_q < first_usable_q) begin
						ex_status = ST_BAD_PAGE;
					end else if (cnt_rdata == '0) begin
						ex_status = ST_UNDERFLOW;
					end else begin
						ex_cnt_we   = 1'b1;
						ex_cnt_data = cnt_rdata - COUNT_BITS'(1);
						ex_count    = ex_cnt_data;
						if (ex_cnt_data == '0) begin
							if (depth_q == FULL_DEPTH) begin
								ex_status = ST_STACK_FULL;
							end else begin
								ex_push  = 1'b1;
								ex_freed = 1'b1;
							end
						end
					end
				end
				MODE_INCREASE: begin
					if (cnt_rdata == COUNT_MAX) begin
						ex_status = ST_OVERFLOW;
					end else begin
						ex_cnt_we   = 1'b1;
						ex_cnt_data = cnt_rdata + COUNT_BITS'(1);
						ex_count    = ex_cnt_data;
					end
				end
				MODE_DECREASE: begin
					if (cnt_rdata == '0) begin
						ex_status = ST_UNDERFLOW;
					end else begin
						ex_cnt_we   = 1'b1;
						ex_cnt_data = cnt_rdata - COUNT_BITS'(1);
						ex_count    = ex_cnt_data;
					end
				end
				MODE_SET: begin
					ex_cnt_we   = 1'b1;
					ex_cnt_data = COUNT_BITS'(setv_q);
					ex_count    = ex_cnt_data;
				end
				default: begin
					ex_count = cnt_rdata;
				end
			endcase
		end
	end

	// ram write muxing
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = walk_q;
		cnt_wdata = '0;
		stk_we    = 1'b0;
		stk_waddr = depth_q[AW-1:0];
		stk_wdata = walk_q;
		unique case (state_q)
			S_CLEAR: begin
				cnt_we = 1'b1;
			end
			S_WALK: begin
				cnt_we = 1'b1;
				stk_we = 1'b1;
			end
			S_EXEC: begin
				cnt_we    = exec_go && ex_cnt_we;
				cnt_waddr = ex_cnt_addr;
				cnt_wdata = ex_cnt_data;
				stk_we    = exec_go && ex_push;
				stk_wdata = AW'(page_q);
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_usable_q <= '0;
		end else if (cfg_wr_en) begin
			first_usable_q <= cfg_wr_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			page_q <= page_index;
			setv_q <= set_value;
		end
	end

	// sequencer, stack depth and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			depth_q <= '0;
			walk_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					walk_q <= walk_q + AW'(1);
					if (walk_q == LAST_PAGE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (mode_q == MODE_INIT) begin
						depth_q <= '0;
						walk_q  <= AW'(first_usable_q);
						state_q <= first_ok ? S_WALK : S_FIN;
					end else if (out_free) begin
						if (ex_pop) begin
							depth_q <= depth_dec;
						end else if (ex_push) begin
							depth_q <= depth_q + DW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					depth_q <= depth_q + DW'(1);
					walk_q  <= walk_q + AW'(1);
					if (walk_q == LAST_PAGE) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// init result held across the walk
	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && (mode_q == MODE_INIT)) begin
			res_page_q  <= ex_page;
			res_count_q <= REFOUT_W'(ex_count);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go || ((state_q == S_FIN) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_page_q   <= ex_page;
			out_count_q  <= REFOUT_W'(ex_count);
			out_freed_q  <= ex_freed;
			out_status_q <= ex_status;
		end else if ((state_q == S_FIN) && out_free) begin
			out_page_q   <= res_page_q;
			out_count_q  <= res_count_q;
			out_freed_q  <= 1'b0;
			out_status_q <= ST_OK;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_page = out_page_q;
	assign ref_count   = out_count_q;
	assign freed       = out_freed_q;
	assign status      = out_status_q;

endmodule

// ===== rtl/rpa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== verif/refcounted_page_allocator_top_tb.sv =====
// testbench for the reference-counted page allocator top level
`timescale 1ns / 1ps

module refcounted_page_allocator_top_tb;
	import rpa_pkg::*;

	localparam int POOL_PAGES = NUM_PAGES_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
	// mode 7 is not an operation of its own and reads like get count
	localparam logic [2:0] MODE_SPARE = 3'd7;
	// inits of the random traffic are only issued when the walk stays short
	localparam int CHEAP_INIT_FLOOR = POOL_PAGES - 1024;
	localparam int IDLE_LIMIT = 100000;
	localparam int LIVE_MAX = 64;

	typedef struct {
		logic [PAGE_W-1:0]   page;
		logic [REFOUT_W-1:0] count;
		logic                freed;
		status_t             status;
	} page_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [PAGE_W-1:0]   cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          mode = '0;
	logic [PAGE_W-1:0]   page_index = '0;
	logic [SETVAL_W-1:0] set_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PAGE_W-1:0]   result_page;
	logic [REFOUT_W-1:0] ref_count;
	logic                freed;
	logic [2:0]          status;

	// predicted allocator state
	bit [COUNT_BITS_DEF-1:0] count_table [POOL_PAGES];
	bit [PAGE_W-1:0]         free_pages [POOL_PAGES];
	int                      free_top = 0;
	int                      first_usable = 0;

	page_result_t      pending_results[$];
	logic [PAGE_W-1:0] live_pages[$];
	int                mismatches = 0;
	int                burst_left = 0;
	int                hold_off_len = 0;
	int                idle_cycles = 0;

	refcounted_page_allocator_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.page_index  (page_index),
		.set_value   (set_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_page (result_page),
		.ref_count   (ref_count),
		.freed       (freed),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predict one operation and update the allocator state
	function automatic page_result_t apply_page_op(input logic [2:0] op,
		input logic [PAGE_W-1:0] pg, input logic [SETVAL_W-1:0] sv);
		page_result_t r;
		int p;
		r = '{page: pg, count: '0, freed: 1'b0, status: ST_OK};
		if (op == MODE_INIT) begin
			free_top = 0;
			for (p = first_usable; p < POOL_PAGES; p++) begin
				count_table[p] = '0;
				free_pages[free_top] = p[PAGE_W-1:0];
				free_top++;
			end
			r.count = count_table[pg];
		end else if (op == MODE_ALLOC) begin
			if (free_top == 0) begin
				r.page = '0;
				r.status = ST_OUT_OF_MEM;
			end else begin
				free_top--;
				r.page = free_pages[free_top];
				count_table[r.page] = COUNT_BITS_DEF'(1);
				r.count = REFOUT_W'(1);
			end
		end else if (int'(pg) >= POOL_PAGES) begin
			r.status = ST_BAD_PAGE;
		end else begin
			case (op)
				MODE_FREE: begin
					if (int'(pg) < first_usable) begin
						r.count = count_table[pg];
						r.status = ST_BAD_PAGE;
					end else if (count_table[pg] == 0) begin
						r.status = ST_UNDERFLOW;
					end else begin
						count_table[pg]--;
						r.count = count_table[pg];
						// last reference gone: back on the stack unless it is full
						if (count_table[pg] == 0) begin
							if (free_top >= POOL_PAGES) begin
								r.status = ST_STACK_FULL;
							end else begin
								free_pages[free_top] = pg;
								free_top++;
								r.freed = 1'b1;
							end
						end
					end
				end
				MODE_INCREASE: begin
					if (count_table[pg] == COUNT_MAX) begin
						r.status = ST_OVERFLOW;
					end else begin
						count_table[pg]++;
					end
					r.count = count_table[pg];
				end
				MODE_DECREASE: begin
					if (count_table[pg] == 0) begin
						r.status = ST_UNDERFLOW;
					end else begin
						count_table[pg]--;
					end
					r.count = count_table[pg];
				end
				MODE_SET: begin
					count_table[pg] = sv;
					r.count = count_table[pg];
				end
				default: begin
					r.count = count_table[pg];
				end
			endcase
		end
		return r;
	endfunction

	// one item transfer; valid stays high for a following item of the burst
	task automatic send_page_op(input logic [2:0] op, input logic [PAGE_W-1:0] pg,
		input logic [SETVAL_W-1:0] sv);
		page_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= op;
		page_index <= pg;
		set_value <= sv;
		do @(posedge clk); while (in_stall);
		burst_left--;
		r = apply_page_op(op, pg, sv);
		pending_results.push_back(r);
		if (op == MODE_ALLOC && r.status == ST_OK && live_pages.size() < LIVE_MAX)
			live_pages.push_back(r.page);
	endtask

	// stop sending and wait until the block has delivered everything
	task automatic finish_outstanding();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_first_usable(input int value);
		finish_outstanding();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[PAGE_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		first_usable = value;
	endtask

	// mostly pages in play, some in the usable window, some anywhere
	function automatic logic [PAGE_W-1:0] pick_page();
		int sel;
		int span;
		sel = $urandom_range(0, 9);
		span = POOL_PAGES - 1 - first_usable;
		if (span > 63)
			span = 63;
		if (sel < 5 && live_pages.size() > 0)
			return live_pages[$urandom_range(0, live_pages.size() - 1)];
		if (sel < 8 && span >= 0)
			return PAGE_W'(first_usable + $urandom_range(0, span));
		return PAGE_W'($urandom_range(0, POOL_PAGES - 1));
	endfunction

	function automatic logic [SETVAL_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return SETVAL_W'(1);
			3: return SETVAL_W'(COUNT_MAX - 1);
			default: return SETVAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// alloc / count edits / free on pages in play, with some noise
	task automatic send_random_op();
		int sel;
		int idx;
		logic [2:0] op;
		logic [PAGE_W-1:0] pg;
		sel = $urandom_range(0, 99);
		pg = pick_page();
		if (sel < 25) begin
			op = MODE_ALLOC;
		end else if (sel < 45) begin
			op = MODE_FREE;
			if (live_pages.size() > 0 && $urandom_range(0, 9) < 7) begin
				idx = $urandom_range(0, live_pages.size() - 1);
				pg = live_pages[idx];
				live_pages.delete(idx);
			end
		end else if (sel < 60) begin
			op = MODE_INCREASE;
		end else if (sel < 70) begin
			op = MODE_DECREASE;
		end else if (sel < 80) begin
			op = MODE_SET;
		end else if (sel < 88) begin
			op = MODE_GET;
		end else if (sel < 92) begin
			op = MODE_SPARE;
		end else if (sel < 95) begin
			op = (first_usable >= CHEAP_INIT_FLOOR) ? MODE_INIT : MODE_GET;
		end else begin
			op = 3'($urandom_range(0, 7));
			pg = PAGE_W'($urandom_range(0, POOL_PAGES - 1));
			if (op == MODE_INIT && first_usable < CHEAP_INIT_FLOOR)
				op = MODE_GET;
		end
		if (op == MODE_INIT)
			live_pages.delete();
		send_page_op(op, pg, pick_count());
	endtask

	task automatic test_empty_pool();
		send_page_op(MODE_ALLOC, 15'h7fff, '1);
		send_page_op(MODE_GET, 15'h7fff, '0);
		send_page_op(MODE_SPARE, '0, '0);
	endtask

	task automatic test_count_limits();
		send_page_op(MODE_SET, 15'd5, '1);
		send_page_op(MODE_INCREASE, 15'd5, '0);
		send_page_op(MODE_DECREASE, 15'd5, '0);
		send_page_op(MODE_SET, 15'd5, '0);
		send_page_op(MODE_DECREASE, 15'd5, '0);
		send_page_op(MODE_INCREASE, 15'h7fff, 8'haa);
	endtask

	task automatic test_free_and_reuse();
		send_page_op(MODE_SET, 15'd10, 8'd2);
		send_page_op(MODE_FREE, 15'd10, '0);
		send_page_op(MODE_FREE, 15'd10, '0);
		send_page_op(MODE_FREE, 15'd10, '0);
		send_page_op(MODE_ALLOC, '0, '0);
		send_page_op(MODE_ALLOC, '0, '0);
	endtask

	// pages left on the stack below a raised usable floor
	task automatic test_below_usable();
		write_first_usable(POOL_PAGES - 4);
		send_page_op(MODE_INIT, 15'h7fff, '0);
		write_first_usable(POOL_PAGES - 1);
		repeat (4) send_page_op(MODE_ALLOC, '0, '0);
		send_page_op(MODE_FREE, PAGE_W'(POOL_PAGES - 4), '0);
		send_page_op(MODE_FREE, PAGE_W'(POOL_PAGES - 1), '0);
	endtask

	// full walk from page zero, then a free into the full stack
	task automatic test_stack_full();
		write_first_usable(0);
		send_page_op(MODE_INIT, '0, '0);
		send_page_op(MODE_SET, 15'd100, 8'd1);
		send_page_op(MODE_FREE, 15'd100, '0);
		send_page_op(MODE_ALLOC, '0, '0);
	endtask

	task automatic test_random_traffic(input int floor_page, input int n_items);
		write_first_usable(floor_page);
		if (floor_page >= CHEAP_INIT_FLOOR) begin
			live_pages.delete();
			send_page_op(MODE_INIT, pick_page(), '0);
		end
		repeat (n_items) send_random_op();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure(input int n_items);
		finish_outstanding();
		hold_off_len = 400;
		repeat (n_items) send_random_op();
	endtask

	// receiver stall pattern, with a long hold-off on request
	initial begin : result_stall_gen
		int seg_left;
		int kind;
		seg_left = 0;
		kind = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
				out_stall <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					kind = $urandom_range(0, 3);
					seg_left = $urandom_range(16, 160);
				end
				seg_left--;
				case (kind)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (seg_left % 3 == 0);
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// compare each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: page %0d count %0d freed %0d status %0d",
					$time, result_page, ref_count, freed, status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_page", want.page, result_page);
				check_field("ref_count", want.count, ref_count);
				check_field("freed", want.freed, freed);
				check_field("status", want.status, status);
			end
		end
	end

	// no transfer on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pool();
		test_count_limits();
		test_free_and_reuse();
		test_below_usable();
		test_stack_full();
		test_random_traffic(POOL_PAGES - 1, 200);
		test_random_traffic(POOL_PAGES - 68, 200);
		test_random_traffic(POOL_PAGES - $urandom_range(16, 512), 200);
		test_random_traffic(0, 200);
		test_random_traffic($urandom_range(0, POOL_PAGES - 1), 200);
		test_random_traffic(POOL_PAGES - $urandom_range(2, 64), 200);
		test_backpressure(80);
		finish_outstanding();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
